// ===== sv/zero_segment_hex_encoder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Zero-segment hex encoder assertion macros
// Concurrent assertion shorthands clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ZERO_SEGMENT_HEX_ENCODER_UNIT_MACROS_SVH
`define ZERO_SEGMENT_HEX_ENCODER_UNIT_MACROS_SVH

// same-cycle implication
`define ZSH_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ZSH_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/zsh_pkg.sv =====
// ----------------------------------------------------------------------------
// Zero-segment hex encoder package
// Shared constants, record types and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package zsh_pkg;

   localparam int SEG_BYTES        = 16;
   localparam int SEG_IDX_W        = $clog2(SEG_BYTES);
   localparam int MAX_LINE_WIDTH   = 4096;
   localparam int LINE_W_W         = 13;
   localparam int COL_W            = 12;
   localparam int LINE_WIDTH_RESET = 512;
   localparam int HEX_CHARS        = 2 * SEG_BYTES;
   localparam int POS_W            = $clog2(HEX_CHARS + 1);
   localparam int QUEUE_DEPTH      = 2;
   localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   localparam logic [7:0] CHAR_A    = 8'h61;
   localparam logic [7:0] CHAR_B    = 8'h62;
   localparam logic [7:0] CHAR_C    = 8'h63;
   localparam logic [7:0] CHAR_D    = 8'h64;
   localparam logic [7:0] CHAR_E    = 8'h65;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_UPA  = 8'h41;

   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONES = 8'hFF;
   localparam logic [7:0] BYTE_X22  = 8'h22;
   localparam logic [7:0] BYTE_X88  = 8'h88;

   // register index, i.e. byte address / 4
   typedef enum logic [0:0] {
      REG_LINE_WIDTH = 1'b0
   } csr_reg_type;

   typedef enum logic [2:0] {
      KIND_DATA,
      KIND_ZERO,
      KIND_ONES,
      KIND_X22,
      KIND_X88
   } kind_type;

   typedef struct packed {
      kind_type                     kind;
      logic                         done;
      logic [SEG_BYTES-1:0][7:0]    data;
   } rec_type;

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) begin
         hex_char = CHAR_ZERO + {4'b0, v};
      end else begin
         hex_char = CHAR_UPA + {4'b0, v} - 8'd10;
      end
   endfunction

   function automatic logic [7:0] kind_char(input kind_type k);
      case (k)
         KIND_ZERO: kind_char = CHAR_B;
         KIND_ONES: kind_char = CHAR_C;
         KIND_X22:  kind_char = CHAR_D;
         KIND_X88:  kind_char = CHAR_E;
         default:   kind_char = CHAR_A;
      endcase
   endfunction

   function automatic logic [LINE_W_W-1:0] clamp_width(input logic [CSR_DATA_W-1:0] v);
      logic [LINE_W_W-1:0] w;
      w = v[LINE_W_W-1:0];
      if (w < LINE_W_W'(SEG_BYTES)) begin
         clamp_width = LINE_W_W'(SEG_BYTES);
      end else if (w > LINE_W_W'(MAX_LINE_WIDTH)) begin
         clamp_width = LINE_W_W'(MAX_LINE_WIDTH);
      end else begin
         clamp_width = w;
      end
   endfunction

endpackage

`default_nettype wire

// ===== sv/zsh_queue.sv =====
// ----------------------------------------------------------------------------
// Zero-segment hex encoder record queue
// Small first-word-fall-through queue of finished records.
// ----------------------------------------------------------------------------
`default_nettype none

module zsh_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  zsh_pkg::rec_type      push_rec,
   input  wire logic             pop,
   output logic                  full,
   output logic                  valid,
   output zsh_pkg::rec_type      head
);

   zsh_pkg::rec_type                    entry_ff [zsh_pkg::QUEUE_DEPTH];
   logic [zsh_pkg::QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [zsh_pkg::QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [zsh_pkg::QCNT_W-1:0]          count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == zsh_pkg::QPTR_W'(zsh_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + zsh_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == zsh_pkg::QPTR_W'(zsh_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + zsh_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + zsh_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - zsh_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   assign full  = (count_ff == zsh_pkg::QCNT_W'(zsh_pkg::QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head  = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== sv/zsh_front.sv =====
// ----------------------------------------------------------------------------
// Zero-segment hex encoder front end
// Takes pixels, tracks the column, gathers segments and classifies records.
// ----------------------------------------------------------------------------
`default_nettype none

module zsh_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [zsh_pkg::LINE_W_W-1:0]  line_width,
   input  wire logic                          restart,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [7:0]                    req_tdata,
   input  wire logic                          q_full,
   output logic                               q_push,
   output zsh_pkg::rec_type                   q_rec
);

   localparam int SB = zsh_pkg::SEG_BYTES;
   localparam int IW = zsh_pkg::SEG_IDX_W;
   localparam int LW = zsh_pkg::LINE_W_W;

   logic [zsh_pkg::COL_W-1:0]   col_ff, col_in;
   logic [3:0]                  flags_ff, flags_in;
   logic [SB-1:0][7:0]          seg_ff, seg_in;
   logic [SB-1:0][7:0]          last_ff, last_in;

   logic                        accept;
   logic [LW-1:0]               p_ext;
   logic [IW-1:0]               idx;
   logic                        done;
   logic [LW-1:0]               full_end;
   logic                        in_full;
   logic [3:0]                  match;
   logic [3:0]                  flags_now;
   logic                        seg_end;
   logic                        rem_end;
   logic [SB-1:0][7:0]          new_last;
   zsh_pkg::kind_type           kind;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      p_ext    = {1'b0, col_ff};
      idx      = col_ff[IW-1:0];
      done     = (p_ext + LW'(1)) >= line_width;
      full_end = {line_width[LW-1:IW], {IW{1'b0}}};
      in_full  = p_ext < full_end;
      match    = {req_tdata == zsh_pkg::BYTE_X88, req_tdata == zsh_pkg::BYTE_X22,
                  req_tdata == zsh_pkg::BYTE_ONES, req_tdata == zsh_pkg::BYTE_ZERO};
      flags_now = ((idx == '0) ? 4'hF : flags_ff) & match;
      seg_end   = in_full && (idx == IW'(SB - 1));
      rem_end   = !in_full && done;

      // bytes the record carries: a whole segment replaces all, a remainder
      // replaces only its leading bytes
      for (int i = 0; i < SB; i++) begin
         if (IW'(i) == idx) begin
            new_last[i] = req_tdata;
         end else if (in_full || (IW'(i) < idx)) begin
            new_last[i] = seg_ff[i];
         end else begin
            new_last[i] = last_ff[i];
         end
      end

      if (!in_full) begin
         kind = zsh_pkg::KIND_DATA;
      end else if (flags_now[0]) begin
         kind = zsh_pkg::KIND_ZERO;
      end else if (flags_now[1]) begin
         kind = zsh_pkg::KIND_ONES;
      end else if (flags_now[2]) begin
         kind = zsh_pkg::KIND_X22;
      end else if (flags_now[3]) begin
         kind = zsh_pkg::KIND_X88;
      end else begin
         kind = zsh_pkg::KIND_DATA;
      end

      col_in   = col_ff;
      flags_in = flags_ff;
      seg_in   = seg_ff;
      last_in  = last_ff;
      q_push   = 1'b0;
      if (restart) begin
         col_in   = '0;
         flags_in = 4'hF;
      end else if (accept) begin
         seg_in[idx] = req_tdata;
         col_in      = done ? '0 : col_ff + zsh_pkg::COL_W'(1);
         if (in_full) begin
            flags_in = seg_end ? 4'hF : flags_now;
         end
         q_push = seg_end || rem_end;
         if (rem_end || (seg_end && !flags_now[0])) begin
            last_in = new_last;
         end
      end

      q_rec.kind = kind;
      q_rec.done = done;
      q_rec.data = new_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         flags_ff <= 4'hF;
         last_ff  <= {SB{zsh_pkg::BYTE_ONES}};
      end else begin
         col_ff   <= col_in;
         flags_ff <= flags_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
   end

endmodule

`default_nettype wire

// ===== sv/zsh_back.sv =====
// ----------------------------------------------------------------------------
// Zero-segment hex encoder back end
// Turns queued records into characters, one per cycle unless rsp_tready stalls, via an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module zsh_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  zsh_pkg::rec_type      q_head,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   localparam int PW = zsh_pkg::POS_W;
   localparam int IW = zsh_pkg::SEG_IDX_W;

   logic [PW-1:0]   pos_ff, pos_in;
   logic            valid_ff, valid_in;
   logic [7:0]      char_ff, char_in;
   logic            last_ff, last_in;
   logic            done_ff, done_in;

   logic            load;
   logic [PW-1:0]   k;
   logic [7:0]      sel_byte;
   logic [7:0]      cur_char;
   logic            cur_last;

   always_comb begin
      load     = q_valid && (!valid_ff || rsp_tready);
      k        = pos_ff - PW'(1);
      sel_byte = q_head.data[k[IW:1]];
      if (pos_ff == '0) begin
         cur_char = zsh_pkg::kind_char(q_head.kind);
      end else begin
         cur_char = zsh_pkg::hex_char(k[0] ? sel_byte[3:0] : sel_byte[7:4]);
      end
      cur_last = (q_head.kind != zsh_pkg::KIND_DATA) ||
                 (pos_ff == PW'(zsh_pkg::HEX_CHARS));
      q_pop    = load && cur_last;

      pos_in   = pos_ff;
      valid_in = valid_ff && !rsp_tready;
      char_in  = char_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      if (load) begin
         pos_in   = cur_last ? '0 : pos_ff + PW'(1);
         valid_in = 1'b1;
         char_in  = cur_char;
         last_in  = cur_last;
         done_in  = q_head.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

endmodule

`default_nettype wire

// ===== sv/zero_segment_hex_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// Zero-segment hex encoder
// Cuts 8-bit grey image lines into 16-byte segments and sends each as a
// one-letter record or as 'a' plus 32 uppercase hex characters.
// ----------------------------------------------------------------------------
// Usage: pixels enter on req_* in raster order, one per request; characters
// leave on rsp_* one per request. A uniform segment (all 0x00, 0xFF, 0x22 or
// 0x88) becomes one letter 'b'..'e'; any other segment, and every line tail
// shorter than 16 pixels, becomes 'a' plus 32 hex digits, tlast on the final
// character and tuser on every character of a record that closes a line. The
// front end takes one pixel per cycle as long as its two-entry record queue
// has room; the back end emits one character per cycle unless rsp_tready
// stalls it. A hex record is 33 characters and a letter record one, so
// lines of hex segments give 33 characters per 16 pixels, and uniform
// segments one letter per 16 pixels. A line tail also costs 33 characters
// however short it is, so the narrowest lines (a hex segment plus a
// one-pixel tail, 66 characters per 17 pixels) give the most characters
// per pixel. line_width (register 0, byte address 0) is clamped to
// 16..4096, resets to 512, and every write restarts the line; write it
// only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "zero_segment_hex_encoder_unit_macros.svh"

module zero_segment_hex_encoder_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // pixel requests
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,   // [7:0] pixel
   // character responses
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [7:0]                             rsp_tdata,   // [7:0] out_char
   output logic                                   rsp_tlast,   // run_last
   output logic                                   rsp_tuser,   // [0] line_done
   // configuration
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [zsh_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [zsh_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [zsh_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   logic [zsh_pkg::LINE_W_W-1:0]  line_width_ff, line_width_in;
   logic                          csr_wr;
   logic                          hit_width;

   logic                          q_push;
   logic                          q_full;
   logic                          q_valid;
   logic                          q_pop;
   zsh_pkg::rec_type              q_rec;
   zsh_pkg::rec_type              q_head;

   logic                          rsp_is_letter;
   logic                          rsp_is_open;

   // --- register file: one register, decoded on the word index bit
   assign csr_pready = 1'b1;
   assign hit_width  = (csr_paddr[2] == zsh_pkg::REG_LINE_WIDTH);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      line_width_in = line_width_ff;
      if (csr_wr && hit_width) begin
         line_width_in = zsh_pkg::clamp_width(csr_pwdata);
      end
      csr_prdata = hit_width ?
                   {{(zsh_pkg::CSR_DATA_W - zsh_pkg::LINE_W_W){1'b0}}, line_width_ff} :
                   '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= zsh_pkg::LINE_W_W'(zsh_pkg::LINE_WIDTH_RESET);
      end else begin
         line_width_ff <= line_width_in;
      end
   end

   // --- front end: column tracking, segment gather, classification
   zsh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .line_width (line_width_ff),
      .restart    (csr_wr && hit_width),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_rec      (q_rec)
   );

   // --- record queue decouples the two sides
   zsh_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (q_rec),
      .pop      (q_pop),
      .full     (q_full),
      .valid    (q_valid),
      .head     (q_head)
   );

   // --- back end: character serializer with output register
   zsh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // --- assertions
   // hex digits are uppercase, so lowercase letters only ever start a record
   assign rsp_is_letter = (rsp_tdata == zsh_pkg::CHAR_B) || (rsp_tdata == zsh_pkg::CHAR_C) ||
                          (rsp_tdata == zsh_pkg::CHAR_D) || (rsp_tdata == zsh_pkg::CHAR_E);
   assign rsp_is_open   = (rsp_tdata == zsh_pkg::CHAR_A);

   `ZSH_ASSERT_SAME(a_pop_needs_record, q_pop, q_valid, "pop from empty record queue")
   `ZSH_ASSERT_NEXT(a_pop_shows_char, q_pop, rsp_tvalid, "record closed without output")
   `ZSH_ASSERT_SAME(a_letter_is_last, rsp_tvalid && rsp_is_letter, rsp_tlast, "letter no tlast")
   `ZSH_ASSERT_SAME(a_data_letter_open, rsp_tvalid && rsp_is_open, !rsp_tlast, "data rec closed")

endmodule

`default_nettype wire
